// File: hdl/cbm_pkg.sv
// Shared types, codes and constants of the cartridge bank mapper.
package cbm_pkg;

   // Work RAM geometry
   localparam int WRAM_BYTES = 8192;
   localparam int WRAM_AW    = $clog2(WRAM_BYTES);

   // Field widths
   localparam int FUNC_W   = 2;
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int TARGET_W = 2;
   localparam int MAP_W    = 19;
   localparam int MIRROR_W = 2;
   localparam int MASK_W   = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = MASK_W;

   typedef logic [FUNC_W-1:0]     func_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [DATA_W-1:0]     data_type;
   typedef logic [TARGET_W-1:0]   target_type;
   typedef logic [MAP_W-1:0]      map_type;
   typedef logic [MIRROR_W-1:0]   mirror_type;
   typedef logic [WRAM_AW-1:0]    wram_addr_type;

   // Access kinds
   localparam func_type FUNC_CPU_WRITE = 2'd0;
   localparam func_type FUNC_CPU_READ  = 2'd1;
   localparam func_type FUNC_PPU_FETCH = 2'd2;

   // Result targets
   localparam target_type TARGET_NONE = 2'd0;
   localparam target_type TARGET_PRG  = 2'd1;
   localparam target_type TARGET_WRAM = 2'd2;
   localparam target_type TARGET_CHR  = 2'd3;

   // Mirroring codes
   localparam mirror_type MIRROR_ONE_SCREEN  = 2'd0;
   localparam mirror_type MIRROR_VERTICAL    = 2'd1;
   localparam mirror_type MIRROR_HORIZONTAL  = 2'd2;
   localparam mirror_type MIRROR_FOUR_SCREEN = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_MIRRORING  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HARDWIRED_MIRROR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAM_PRESENT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAM_MASK        = 2'd3;

   // Bank register reset values and the fixed last PRG bank
   localparam data_type PRG_BANK_BASE = 8'hFC;
   localparam data_type PRG_BANK3     = 8'hFF;
   localparam int PRG_BANK_BITS = 6;

   // Result of one access, carried down the pipeline
   typedef struct packed {
      target_type target;
      map_type    mapped_address;
      logic       ram_read;
      mirror_type mirror_mode;
      logic       wram_enabled;
   } stage_type;

endpackage

// File: hdl/cbm_req_if.sv
// Request channel interface: one bus access per item.
interface cbm_req_if;
   logic               valid;
   logic               ready;
   cbm_pkg::func_type  func;
   cbm_pkg::addr_type  address;
   cbm_pkg::data_type  write_data;

   modport source (output valid, output func, output address, output write_data,
                   input ready);
   modport sink   (input valid, input func, input address, input write_data,
                   output ready);
endinterface

// Response channel interface: one translated result per item.
interface cbm_rsp_if;
   logic                 valid;
   logic                 ready;
   cbm_pkg::target_type  target;
   cbm_pkg::map_type     mapped_address;
   cbm_pkg::data_type    read_data;
   cbm_pkg::mirror_type  mirror_mode;
   logic                 wram_enabled;

   modport source (output valid, output target, output mapped_address,
                   output read_data, output mirror_mode, output wram_enabled,
                   input ready);
   modport sink   (input valid, input target, input mapped_address,
                   input read_data, input mirror_mode, input wram_enabled,
                   output ready);
endinterface

// File: hdl/cartridge_bank_mapper_unit.sv
// Top level of the cartridge bank mapper: decode, bank registers, work RAM and output stage.
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    func, address, write_data
//   rsp_chan  out        valid / ready    target, mapped_address, read_data,
//                                         mirror_mode, wram_enabled
//   csr_*     in         csr_we           csr_index, csr_wdata
//
// One item per cycle sustained while the response side is ready. The work RAM read
// is registered at the edge that accepts the item, together with the stage-1 register;
// the result register loads from both when stage 1 moves on, which a stall can hold off.
// Bank and enable registers update at the edge that accepts a write item.
// Synchronous active-high reset restores the bank registers and configuration
// to their start values and clears the valid flags; work RAM is not cleared.
// A stalled result holds the pipeline; the request side stays ready while a
// stage ahead can move.
module cartridge_bank_mapper_unit (
   input  logic                               clock,
   input  logic                               reset,
   cbm_req_if.sink                            req_chan,
   cbm_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers
   logic                              fixed_mirror_ff;
   cbm_pkg::mirror_type               hw_mirror_ff;
   logic                              wram_present_ff;
   logic [cbm_pkg::MASK_W-1:0]        wram_mask_ff;

   // Bank registers
   cbm_pkg::data_type                 prg_bank_ff [3];
   cbm_pkg::data_type                 prg_bank_in [3];
   cbm_pkg::data_type                 chr_bank_ff [8];
   cbm_pkg::data_type                 chr_bank_in [8];
   logic                              ram_en_ff;
   logic                              ram_en_in;

   // Pipeline
   logic                              s1_valid_ff;
   cbm_pkg::stage_type                s1_ff;
   cbm_pkg::stage_type                s1_in;
   logic                              out_valid_ff;
   cbm_pkg::stage_type                out_ff;
   cbm_pkg::data_type                 out_rdata_ff;

   logic                              accept;
   logic                              s1_move;
   logic                              out_free;

   // Decode
   logic                              hit_wram;
   logic                              wram_wr;
   logic                              wram_rd;
   cbm_pkg::wram_addr_type            wram_addr;
   cbm_pkg::data_type                 wram_rdata;
   logic [cbm_pkg::MASK_W-1:0]        wram_offset;
   logic [cbm_pkg::PRG_BANK_BITS-1:0] prg_sel;
   logic [1:0]                        prg_idx;

   // Handshake
   assign out_free      = !out_valid_ff || rsp_chan.ready;
   assign s1_move       = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept        = req_chan.valid && req_chan.ready;

   // Work RAM address: offset into the window, mirrored by mask and size
   assign hit_wram    = (req_chan.address[15:13] == 3'b011) && wram_present_ff;
   assign wram_offset = req_chan.address[cbm_pkg::MASK_W-1:0] & wram_mask_ff;
   assign wram_addr   = wram_offset[cbm_pkg::WRAM_AW-1:0];
   assign wram_wr     = accept && hit_wram && (req_chan.func == cbm_pkg::FUNC_CPU_WRITE);
   assign wram_rd     = accept && hit_wram && (req_chan.func == cbm_pkg::FUNC_CPU_READ);

   cbm_wram u_wram (
      .clock   (clock),
      .wr_en   (wram_wr),
      .rd_en   (wram_rd),
      .addr    (wram_addr),
      .wr_data (req_chan.write_data),
      .rd_data (wram_rdata)
   );

   // PRG bank lookup for CPU reads
   assign prg_idx = req_chan.address[14:13];
   always_comb begin
      if (prg_idx == 2'd3) begin
         prg_sel = cbm_pkg::PRG_BANK3[cbm_pkg::PRG_BANK_BITS-1:0];
      end else begin
         prg_sel = prg_bank_ff[prg_idx][cbm_pkg::PRG_BANK_BITS-1:0];
      end
   end

   // Next values of the bank and enable registers
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prg_bank_in[i] = prg_bank_ff[i];
      end
      for (int i = 0; i < 8; i++) begin
         chr_bank_in[i] = chr_bank_ff[i];
      end
      ram_en_in = ram_en_ff;
      if (accept && req_chan.func == cbm_pkg::FUNC_CPU_WRITE) begin
         if (req_chan.address[15:14] == 2'b10) begin
            chr_bank_in[req_chan.address[13:11]] = req_chan.write_data;
         end else if (req_chan.address[15:13] == 3'b110) begin
            ram_en_in = req_chan.write_data[0];
         end else if (req_chan.address[15:13] == 3'b111 &&
                      req_chan.address[12:11] != 2'b11) begin
            prg_bank_in[req_chan.address[12:11]] = req_chan.write_data;
         end
      end
   end

   // Build the result of the accepted item
   always_comb begin
      s1_in                = '0;
      s1_in.wram_enabled   = ram_en_in;
      if (fixed_mirror_ff) begin
         s1_in.mirror_mode = hw_mirror_ff;
      end else begin
         unique case (prg_bank_in[0][7:6])
            2'd1:    s1_in.mirror_mode = cbm_pkg::MIRROR_VERTICAL;
            2'd2:    s1_in.mirror_mode = cbm_pkg::MIRROR_HORIZONTAL;
            default: s1_in.mirror_mode = cbm_pkg::MIRROR_ONE_SCREEN;
         endcase
      end
      unique case (req_chan.func)
         cbm_pkg::FUNC_CPU_WRITE: begin
            if (hit_wram) begin
               s1_in.target = cbm_pkg::TARGET_WRAM;
            end
         end
         cbm_pkg::FUNC_CPU_READ: begin
            if (hit_wram) begin
               s1_in.target   = cbm_pkg::TARGET_WRAM;
               s1_in.ram_read = 1'b1;
            end else if (req_chan.address[15]) begin
               s1_in.target         = cbm_pkg::TARGET_PRG;
               s1_in.mapped_address = {prg_sel, req_chan.address[12:0]};
            end
         end
         cbm_pkg::FUNC_PPU_FETCH: begin
            if (req_chan.address[15:13] == 3'b000) begin
               s1_in.target         = cbm_pkg::TARGET_CHR;
               s1_in.mapped_address = {1'b0, chr_bank_ff[req_chan.address[12:10]],
                                       req_chan.address[9:0]};
            end
         end
         default: begin
            s1_in.target = cbm_pkg::TARGET_NONE;
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_mirror_ff <= 1'b0;
         hw_mirror_ff    <= '0;
         wram_present_ff <= 1'b1;
         wram_mask_ff    <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            cbm_pkg::CSR_FIXED_MIRRORING:  fixed_mirror_ff <= csr_wdata[0];
            cbm_pkg::CSR_HARDWIRED_MIRROR: hw_mirror_ff    <= csr_wdata[1:0];
            cbm_pkg::CSR_WRAM_PRESENT:     wram_present_ff <= csr_wdata[0];
            cbm_pkg::CSR_WRAM_MASK:        wram_mask_ff    <= csr_wdata;
            default:                       wram_mask_ff    <= wram_mask_ff;
         endcase
      end
   end

   // Bank and enable registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            prg_bank_ff[i] <= cbm_pkg::PRG_BANK_BASE | cbm_pkg::data_type'(i);
         end
         for (int i = 0; i < 8; i++) begin
            chr_bank_ff[i] <= cbm_pkg::data_type'(i);
         end
         ram_en_ff <= 1'b0;
      end else begin
         prg_bank_ff <= prg_bank_in;
         chr_bank_ff <= chr_bank_in;
         ram_en_ff   <= ram_en_in;
      end
   end

   // Advance the pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= accept;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Hold payloads; merge work RAM data on the way to the output
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         out_ff       <= s1_ff;
         out_rdata_ff <= s1_ff.ram_read ? wram_rdata : '0;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.target         = out_ff.target;
   assign rsp_chan.mapped_address = out_ff.mapped_address;
   assign rsp_chan.read_data      = out_rdata_ff;
   assign rsp_chan.mirror_mode    = out_ff.mirror_mode;
   assign rsp_chan.wram_enabled   = out_ff.wram_enabled;

endmodule

// File: hdl/cbm_wram.sv
// Work RAM: single-port synchronous memory with registered read data.
module cbm_wram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic                   rd_en,
   input  cbm_pkg::wram_addr_type addr,
   input  cbm_pkg::data_type      wr_data,
   output cbm_pkg::data_type      rd_data
);

   cbm_pkg::data_type mem [cbm_pkg::WRAM_BYTES];
   cbm_pkg::data_type rd_data_ff;

   // Write on enable
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // Read and hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
